// ===== sv/lfpd_pkg.sv =====
`timescale 1ns / 1ps
// lfpd_pkg: widths, reset values, controller codes and helpers for the
// line follower PD drive. No dependencies.
package lfpd_pkg;

    localparam int NUM_SENSE  = 7;
    localparam int SENSE_W    = 12;
    localparam int GAIN_W     = 8;
    localparam int SPEED_W    = 9;
    localparam int ERR_W      = 4;
    localparam int DELTA_W    = ERR_W + 1;
    localparam int PROD_W     = 15;
    localparam int MAG_W      = 13;
    localparam int WIDE_W     = MAG_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int DIV_STEPS  = MAG_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(500);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ON_THR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_THR  = 3'd5;

    localparam logic [GAIN_W-1:0]  KP_RESET      = 8'd10;
    localparam logic [GAIN_W-1:0]  KI_RESET      = 8'd2;
    localparam logic [GAIN_W-1:0]  KD_RESET      = 8'd5;
    localparam logic [SPEED_W-1:0] BASE_RESET    = 9'd150;
    localparam logic [SENSE_W-1:0] ON_THR_RESET  = 12'd200;
    localparam logic [SENSE_W-1:0] OFF_THR_RESET = 12'd100;

    // controller state codes
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_SUM  = 3'd2;
    localparam logic [ST_W-1:0] ST_DIV  = 3'd3;
    localparam logic [ST_W-1:0] ST_DONE = 3'd4;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic div_step;
        logic finish;
    } lfpd_cmd_t;

    typedef struct packed {
        logic out_free;
    } lfpd_stat_t;

    function automatic logic [SPEED_W-1:0] clamp_speed(input logic [WIDE_W-1:0] v);
        logic [SPEED_W-1:0] r;
        if (v > WIDE_W'(SPEED_MAX))
            r = SPEED_MAX;
        else
            r = v[SPEED_W-1:0];
        return r;
    endfunction

endpackage

// ===== sv/lfpd_scan_if.sv =====
`timescale 1ns / 1ps
// lfpd_scan_if: input channel, one sensor scan per beat
// depends on lfpd_pkg
interface lfpd_scan_if;
    import lfpd_pkg::*;

    logic               valid;
    logic               ready;
    logic [SENSE_W-1:0] sense_1;
    logic [SENSE_W-1:0] sense_2;
    logic [SENSE_W-1:0] sense_3;
    logic [SENSE_W-1:0] sense_4;
    logic [SENSE_W-1:0] sense_5;
    logic [SENSE_W-1:0] sense_6;
    logic [SENSE_W-1:0] sense_7;
    logic               run_enable;

    modport source (
        output valid, sense_1, sense_2, sense_3, sense_4, sense_5, sense_6, sense_7,
               run_enable,
        input  ready
    );
    modport sink (
        input  valid, sense_1, sense_2, sense_3, sense_4, sense_5, sense_6, sense_7,
               run_enable,
        output ready
    );
endinterface

// ===== sv/lfpd_drive_if.sv =====
`timescale 1ns / 1ps
// lfpd_drive_if: output channel, wheel speeds and line status per beat
// depends on lfpd_pkg
interface lfpd_drive_if;
    import lfpd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [SPEED_W-1:0]      left_speed;
    logic [SPEED_W-1:0]      right_speed;
    logic                    apply_drive;
    logic signed [ERR_W-1:0] position_error;
    logic                    line_lost;

    modport source (
        output valid, left_speed, right_speed, apply_drive, position_error, line_lost,
        input  ready
    );
    modport sink (
        input  valid, left_speed, right_speed, apply_drive, position_error, line_lost,
        output ready
    );
endinterface

// ===== sv/lfpd_ctrl.sv =====
`timescale 1ns / 1ps
// lfpd_ctrl: sequencing state machine for the PD drive datapath
// depends on lfpd_pkg
module lfpd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lfpd_pkg::lfpd_stat_t stat,
    output lfpd_pkg::lfpd_cmd_t  cmd
);
    import lfpd_pkg::*;

    logic [ST_W-1:0]  state_reg;
    logic [ST_W-1:0]  state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // products are formed straight from the incoming scan
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cmd.mul    = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== sv/lfpd_dp.sv =====
`timescale 1ns / 1ps
// lfpd_dp: config registers, error finder, PD products, serial divider
// and output register. depends on lfpd_pkg
module lfpd_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [lfpd_pkg::SENSE_W-1:0]    sense [lfpd_pkg::NUM_SENSE],
    input  logic                          run_enable,
    input  lfpd_pkg::lfpd_cmd_t            cmd,
    output lfpd_pkg::lfpd_stat_t           stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lfpd_pkg::SPEED_W-1:0]    left_speed,
    output logic [lfpd_pkg::SPEED_W-1:0]    right_speed,
    output logic                          apply_drive,
    output logic signed [lfpd_pkg::ERR_W-1:0] position_error,
    output logic                          line_lost
);
    import lfpd_pkg::*;

    logic [GAIN_W-1:0]  kp_reg, ki_reg, kd_reg;
    logic [SPEED_W-1:0] base_reg;
    logic [SENSE_W-1:0] on_thr_reg, off_thr_reg;

    logic signed [ERR_W-1:0]   prev_error_reg;
    logic                      lost_flag_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic                      run_reg;
    logic signed [PROD_W-1:0]  prod_p_reg, prod_d_reg;
    logic [MAG_W-1:0]          mag_reg, quo_reg;
    logic [GAIN_W-1:0]         rem_reg;
    logic                      out_valid_reg;
    logic [SPEED_W-1:0]        left_reg, right_reg;
    logic                      apply_reg, lost_out_reg;
    logic signed [ERR_W-1:0]   err_out_reg;

    // scan decode
    logic signed [ERR_W-1:0]   err_new;
    logic signed [DELTA_W-1:0] delta_new;
    logic                      found;
    logic                      all_low;
    logic                      lost_next;

    always_comb
    begin
        err_new = prev_error_reg;
        found   = 1'b0;
        all_low = 1'b1;
        for (int k = 0; k < NUM_SENSE; k++)
        begin
            if (!found && sense[k] >= on_thr_reg)
            begin
                err_new = ERR_W'(2 * k - 6);
                found   = 1'b1;
            end
            if (sense[k] >= off_thr_reg)
                all_low = 1'b0;
        end
        priority if (all_low)
            lost_next = 1'b1;
        else if (found)
            lost_next = 1'b0;
        else
            lost_next = lost_flag_reg;
    end

    assign delta_new = DELTA_W'(err_new) - DELTA_W'(prev_error_reg);

    // drive term magnitude
    logic signed [PROD_W-1:0] pd_sum;
    logic [MAG_W-1:0]         mag_new;

    assign pd_sum  = prod_p_reg + prod_d_reg;
    assign mag_new = pd_sum[PROD_W-1] ? MAG_W'(-pd_sum) : pd_sum[MAG_W-1:0];

    // one restoring divide step per cycle
    logic [GAIN_W:0]   trial;
    logic              q_bit;
    logic [GAIN_W-1:0] rem_new;

    assign trial   = {rem_reg, quo_reg[MAG_W-1]};
    assign q_bit   = (trial >= {1'b0, ki_reg});
    assign rem_new = q_bit ? GAIN_W'(trial - {1'b0, ki_reg}) : trial[GAIN_W-1:0];

    // wheel speeds
    logic [WIDE_W-1:0]  base_w, outer_w, inner_w;
    logic [SPEED_W-1:0] base_c, outer_c, inner_c;

    always_comb
    begin
        base_w  = WIDE_W'(base_reg);
        outer_w = base_w + WIDE_W'(mag_reg);
        if (lost_flag_reg || ki_reg == '0 || WIDE_W'(quo_reg) > base_w)
            inner_w = '0;
        else
            inner_w = base_w - WIDE_W'(quo_reg);
        base_c  = clamp_speed(base_w);
        outer_c = clamp_speed(outer_w);
        inner_c = clamp_speed(inner_w);
    end

    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg         <= KP_RESET;
            ki_reg         <= KI_RESET;
            kd_reg         <= KD_RESET;
            base_reg       <= BASE_RESET;
            on_thr_reg     <= ON_THR_RESET;
            off_thr_reg    <= OFF_THR_RESET;
            prev_error_reg <= '0;
            lost_flag_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_KP:      kp_reg      <= cfg_data[GAIN_W-1:0];
                    REG_KI:      ki_reg      <= cfg_data[GAIN_W-1:0];
                    REG_KD:      kd_reg      <= cfg_data[GAIN_W-1:0];
                    REG_BASE:    base_reg    <= cfg_data[SPEED_W-1:0];
                    REG_ON_THR:  on_thr_reg  <= cfg_data[SENSE_W-1:0];
                    REG_OFF_THR: off_thr_reg <= cfg_data[SENSE_W-1:0];
                    default:     ;
                endcase
            end
            if (cmd.load)
            begin
                prev_error_reg <= err_new;
                lost_flag_reg  <= lost_next;
            end
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg <= err_new;
            run_reg <= run_enable;
        end
        if (cmd.mul)
        begin
            prod_p_reg <= PROD_W'($signed({1'b0, kp_reg})) * PROD_W'(err_new);
            prod_d_reg <= PROD_W'($signed({1'b0, kd_reg})) * PROD_W'(delta_new);
        end
        if (cmd.sum)
        begin
            mag_reg <= mag_new;
            quo_reg <= mag_new;
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[MAG_W-2:0], q_bit};
            rem_reg <= rem_new;
        end
        if (cmd.finish)
        begin
            apply_reg    <= run_reg;
            err_out_reg  <= err_reg;
            lost_out_reg <= lost_flag_reg;
            if (err_reg < 0)
            begin
                left_reg  <= outer_c;
                right_reg <= inner_c;
            end
            else if (err_reg > 0)
            begin
                left_reg  <= inner_c;
                right_reg <= outer_c;
            end
            else
            begin
                left_reg  <= base_c;
                right_reg <= base_c;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign left_speed     = left_reg;
    assign right_speed    = right_reg;
    assign apply_drive    = apply_reg;
    assign position_error = err_out_reg;
    assign line_lost      = lost_out_reg;

endmodule

// ===== sv/line_follower_pd_drive.sv =====
`timescale 1ns / 1ps
// line_follower_pd_drive: PD line follower, seven sensors to two wheel speeds
// an accepted scan goes through the load with the PD products, the sum, 13 divide
// steps by ki in a restoring divider, and the output load, which waits for the
// output register to free up; one scan is in the bit-serial divider at a time, and a new scan
// is taken while the previous result still waits in the output register
// reset: gains, base speed and thresholds take their defaults, previous error 0,
// line in view, no result pending
module line_follower_pd_drive (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0] cfg_data,
    lfpd_scan_if.sink                       scan,
    lfpd_drive_if.source                    drive
);
    import lfpd_pkg::*;

    lfpd_cmd_t          cmd;
    lfpd_stat_t         stat;
    logic [SENSE_W-1:0] sense [NUM_SENSE];

    assign sense[0] = scan.sense_1;
    assign sense[1] = scan.sense_2;
    assign sense[2] = scan.sense_3;
    assign sense[3] = scan.sense_4;
    assign sense[4] = scan.sense_5;
    assign sense[5] = scan.sense_6;
    assign sense[6] = scan.sense_7;

    lfpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (scan.valid),
        .in_ready (scan.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lfpd_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sense          (sense),
        .run_enable     (scan.run_enable),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (drive.valid),
        .out_ready      (drive.ready),
        .left_speed     (drive.left_speed),
        .right_speed    (drive.right_speed),
        .apply_drive    (drive.apply_drive),
        .position_error (drive.position_error),
        .line_lost      (drive.line_lost)
    );

    // one scan in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        scan.valid && scan.ready |=> !scan.ready)
        else $error("scan taken while another is in flight");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        drive.valid |-> drive.left_speed <= SPEED_MAX && drive.right_speed <= SPEED_MAX)
        else $error("wheel speed above limit");

    // with the line lost and a nonzero error the inner wheel stops
    a_lost_inner_stop: assert property (@(posedge clk) disable iff (!rst_n)
        drive.valid && drive.line_lost && drive.position_error != '0
        |-> drive.left_speed == '0 || drive.right_speed == '0)
        else $error("inner wheel running with line lost");

    a_centre_equal: assert property (@(posedge clk) disable iff (!rst_n)
        drive.valid && drive.position_error == '0 |-> drive.left_speed == drive.right_speed)
        else $error("unequal speeds at zero error");

endmodule

// ===== sim/tb_line_follower_pd_drive.sv =====
`timescale 1ns / 1ps
// tb_line_follower_pd_drive: self-checking bench for the PD line follower drive,
// a directed scan table then random scans under several gain and threshold settings
// depends on lfpd_pkg, lfpd_scan_if, lfpd_drive_if and line_follower_pd_drive
module tb_line_follower_pd_drive;
    import lfpd_pkg::*;

    localparam int N_PHASES        = 6;
    localparam int N_FIXED_PHASES  = 4;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int SETTLE_CYCLES   = 24;
    localparam int MAX_REPORTS     = 10;
    localparam int HOLD_AFTER      = 150;
    localparam int HOLD_CYCLES     = 400;

    // levels picked around the reset thresholds
    localparam logic [SENSE_W-1:0] LO        = 12'd0;
    localparam logic [SENSE_W-1:0] HI        = 12'd4095;
    localparam logic [SENSE_W-1:0] MID       = 12'd150;
    localparam logic [SENSE_W-1:0] AT_ON     = 12'd200;
    localparam logic [SENSE_W-1:0] AT_OFF    = 12'd100;
    localparam logic [SENSE_W-1:0] JUST_DARK = 12'd99;
    localparam logic [SENSE_W-1:0] JUST_DIM  = 12'd199;

    typedef logic [1:7][SENSE_W-1:0] levels_t;

    typedef struct packed {
        logic [SPEED_W-1:0]      left;
        logic [SPEED_W-1:0]      right;
        logic                    apply;
        logic signed [ERR_W-1:0] err;
        logic                    lost;
    } drive_beat_t;

    typedef struct packed {
        levels_t     level;
        logic        run;
        logic        typed;
        drive_beat_t want;
    } scan_row_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [SPEED_W-1:0] base;
        logic [SENSE_W-1:0] on_thr;
        logic [SENSE_W-1:0] off_thr;
    } gains_t;

    typedef enum int {DARK, DIM, BRIGHT, ANY_LEVEL} level_kind_t;

    localparam drive_beat_t NO_WANT = '0;
    localparam int N_ROWS = 22;

    localparam scan_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{'{LO, LO, LO, LO, LO, LO, LO}, 1'b1, 1'b1, '{9'd150, 9'd150, 1'b1, 4'sd0, 1'b1}},
        '{'{HI, HI, HI, HI, HI, HI, HI}, 1'b0, 1'b1, '{9'd240, 9'd105, 1'b0, -4'sd6, 1'b0}},
        '{'{HI, HI, HI, HI, HI, HI, HI}, 1'b1, 1'b1, '{9'd210, 9'd120, 1'b1, -4'sd6, 1'b0}},
        '{'{AT_ON, LO, LO, LO, LO, LO, LO}, 1'b1, 1'b0, NO_WANT},
        '{'{LO, AT_ON, LO, LO, LO, LO, LO}, 1'b1, 1'b0, NO_WANT},
        '{'{LO, LO, AT_ON, LO, LO, LO, LO}, 1'b1, 1'b0, NO_WANT},
        '{'{LO, LO, LO, AT_ON, LO, LO, LO}, 1'b1, 1'b0, NO_WANT},
        '{'{LO, LO, LO, LO, AT_ON, LO, LO}, 1'b1, 1'b0, NO_WANT},
        '{'{LO, LO, LO, LO, LO, AT_ON, LO}, 1'b1, 1'b0, NO_WANT},
        '{'{LO, LO, LO, LO, LO, LO, AT_ON}, 1'b1, 1'b0, NO_WANT},
        // nothing active but not dark: error held
        '{'{LO, LO, LO, JUST_DIM, LO, LO, LO}, 1'b1, 1'b0, NO_WANT},
        '{'{MID, MID, MID, MID, MID, MID, MID}, 1'b0, 1'b0, NO_WANT},
        // full swing from one edge to the other
        '{'{LO, LO, LO, LO, LO, LO, HI}, 1'b1, 1'b0, NO_WANT},
        '{'{HI, LO, LO, LO, LO, LO, LO}, 1'b1, 1'b0, NO_WANT},
        // all just below off: line lost, inner wheel stops
        '{'{JUST_DARK, JUST_DARK, JUST_DARK, JUST_DARK, JUST_DARK, JUST_DARK, JUST_DARK},
            1'b1, 1'b0, NO_WANT},
        '{'{LO, LO, LO, LO, AT_OFF, LO, LO}, 1'b1, 1'b0, NO_WANT},
        '{'{LO, LO, HI, HI, LO, LO, LO}, 1'b1, 1'b0, NO_WANT},
        '{'{LO, LO, LO, LO, HI, HI, LO}, 1'b0, 1'b0, NO_WANT},
        '{'{LO, LO, LO, HI, LO, LO, LO}, 1'b1, 1'b0, NO_WANT},
        '{'{LO, MID, HI, MID, LO, LO, LO}, 1'b1, 1'b0, NO_WANT},
        '{'{LO, LO, LO, LO, LO, HI, HI}, 1'b1, 1'b0, NO_WANT},
        '{'{LO, LO, LO, LO, LO, LO, LO}, 1'b1, 1'b0, NO_WANT}
    };

    // extreme gains, zero gains with crossed thresholds, ki zero with base over range
    localparam gains_t PHASE_GAINS [N_FIXED_PHASES] = '{
        '{8'd255, 8'd1, 8'd255, 9'd500, 12'd4095, 12'd0},
        '{8'd0, 8'd255, 8'd0, 9'd0, 12'd0, 12'd4095},
        '{8'd40, 8'd0, 8'd20, 9'd511, 12'd2048, 12'd1024},
        '{8'd7, 8'd3, 8'd12, 9'd250, 12'd300, 12'd700}
    };

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lfpd_scan_if  scan_ch ();
    lfpd_drive_if drive_ch ();

    line_follower_pd_drive dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .scan      (scan_ch),
        .drive     (drive_ch)
    );

    // predictor state and settings
    int kp_g, ki_g, kd_g, base_sp, on_thr, off_thr;
    int held_err;
    bit line_gone;

    drive_beat_t due_speeds [$];
    int scans_sent;
    int beats_seen;
    int lost_beats;
    int mismatches;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

    function automatic int clamp_duty(int v);
        if (v < 0)
            return 0;
        if (v > 500)
            return 500;
        return v;
    endfunction

    function automatic drive_beat_t steer_speeds(levels_t lv, logic run);
        drive_beat_t b;
        int err, d, mag, q, outer, inner, left, right;
        bit found, dark;
        err = held_err;
        found = 1'b0;
        dark = 1'b1;
        for (int k = 1; k <= 7; k++)
        begin
            if (!found && int'(lv[k]) >= on_thr)
            begin
                err = 2 * k - 8;
                found = 1'b1;
            end
            if (int'(lv[k]) >= off_thr)
                dark = 1'b0;
        end
        if (found)
            line_gone = 1'b0;
        if (dark)
            line_gone = 1'b1;
        d = kp_g * err + kd_g * (err - held_err);
        held_err = err;
        mag = (d < 0) ? -d : d;
        q = (ki_g == 0) ? 32'h7fff_ffff : mag / ki_g;
        outer = base_sp + mag;
        inner = line_gone ? 0 : ((ki_g == 0) ? -1 : base_sp - q);
        if (err < 0)
        begin
            left = outer;
            right = inner;
        end
        else if (err > 0)
        begin
            left = inner;
            right = outer;
        end
        else
        begin
            left = base_sp;
            right = base_sp;
        end
        b.left = SPEED_W'(clamp_duty(left));
        b.right = SPEED_W'(clamp_duty(right));
        b.apply = run;
        b.err = ERR_W'(err);
        b.lost = line_gone;
        return b;
    endfunction

    function automatic logic [SENSE_W-1:0] pick_level(level_kind_t kind);
        case (kind)
            DARK:
                return (off_thr == 0) ? LO : SENSE_W'($urandom_range(off_thr - 1, 0));
            DIM:
            begin
                if (off_thr >= on_thr)
                    return SENSE_W'($urandom_range(4095, 0));
                if ($urandom_range(7, 0) == 0)
                    return SENSE_W'(off_thr);
                return SENSE_W'($urandom_range(on_thr - 1, off_thr));
            end
            BRIGHT:
            begin
                if ($urandom_range(7, 0) == 0)
                    return SENSE_W'(on_thr);
                return SENSE_W'($urandom_range(4095, on_thr));
            end
            default:
                return SENSE_W'($urandom_range(4095, 0));
        endcase
    endfunction

    // mostly a line under one or two adjacent sensors, then lost, dim and noisy scans
    function automatic levels_t random_scan();
        levels_t lv;
        int r, centre, wide;
        r = $urandom_range(99, 0);
        centre = $urandom_range(7, 1);
        wide = $urandom_range(1, 0);
        for (int k = 1; k <= 7; k++)
        begin
            if (r < 55)
            begin
                if (k == centre || (wide == 1 && k == centre + 1))
                    lv[k] = pick_level(BRIGHT);
                else if (k == centre - 1 || k == centre + 1 + wide)
                    lv[k] = pick_level($urandom_range(1, 0) ? DIM : DARK);
                else
                    lv[k] = pick_level(DARK);
            end
            else if (r < 70)
                lv[k] = pick_level(DARK);
            else if (r < 80)
                lv[k] = pick_level($urandom_range(1, 0) ? DIM : DARK);
            else
                lv[k] = pick_level(ANY_LEVEL);
        end
        return lv;
    endfunction

    task automatic offer_scan(levels_t lv, logic run, logic typed, drive_beat_t want);
        drive_beat_t predicted;
        scan_ch.valid      <= 1'b1;
        scan_ch.sense_1    <= lv[1];
        scan_ch.sense_2    <= lv[2];
        scan_ch.sense_3    <= lv[3];
        scan_ch.sense_4    <= lv[4];
        scan_ch.sense_5    <= lv[5];
        scan_ch.sense_6    <= lv[6];
        scan_ch.sense_7    <= lv[7];
        scan_ch.run_enable <= run;
        do
            @(posedge clk);
        while (!scan_ch.ready);
        predicted = steer_speeds(lv, run);
        due_speeds.push_back(typed ? want : predicted);
        scans_sent++;
    endtask

    // gap after a beat; the last scan of a phase always drops valid
    task automatic pause_scans(bit last);
        int r, gap;
        r = $urandom_range(99, 0);
        if (last)
            gap = 1;
        else if (r < 70)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(3, 1);
        else
            gap = $urandom_range(40, 5);
        if (gap > 0)
        begin
            scan_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        case (idx)
            REG_KP:      kp_g = val & 8'hff;
            REG_KI:      ki_g = val & 8'hff;
            REG_KD:      kd_g = val & 8'hff;
            REG_BASE:    base_sp = val & 9'h1ff;
            REG_ON_THR:  on_thr = val & 12'hfff;
            REG_OFF_THR: off_thr = val & 12'hfff;
            default: ;
        endcase
    endtask

    // every item gives a beat, so an empty queue plus the pipeline depth means idle
    task automatic drain();
        while (due_speeds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: random back-pressure with one long hold-off
    initial
    begin
        int r;
        bit held;
        held = 1'b0;
        drive_ch.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            r = $urandom_range(99, 0);
            if (!held && beats_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                drive_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (r < 60)
            begin
                drive_ch.ready <= 1'b1;
                repeat ($urandom_range(40, 1)) @(posedge clk);
            end
            else if (r < 90)
            begin
                drive_ch.ready <= 1'b0;
                repeat ($urandom_range(3, 1)) @(posedge clk);
            end
            else
            begin
                drive_ch.ready <= 1'b0;
                repeat ($urandom_range(60, 10)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        drive_beat_t got;
        drive_beat_t want;
        if (rst_n && drive_ch.valid && drive_ch.ready)
        begin
            got = '{drive_ch.left_speed, drive_ch.right_speed, drive_ch.apply_drive,
                    drive_ch.position_error, drive_ch.line_lost};
            beats_seen++;
            if (got.lost)
                lost_beats++;
            if (due_speeds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected beat l=%0d r=%0d apply=%0b err=%0d lost=%0b",
                             $realtime, got.left, got.right, got.apply, got.err, got.lost);
            end
            else
            begin
                want = due_speeds.pop_front();
                if (got.left !== want.left || got.right !== want.right ||
                    got.apply !== want.apply || got.err !== want.err ||
                    got.lost !== want.lost)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: beat %0d want l=%0d r=%0d apply=%0b err=%0d lost=%0b",
                                 $realtime, beats_seen, want.left, want.right, want.apply,
                                 want.err, want.lost);
                        $display("    got l=%0d r=%0d apply=%0b err=%0d lost=%0b",
                                 got.left, got.right, got.apply, got.err, got.lost);
                    end
                end
            end
        end
    end

    initial
    begin
        gains_t g;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        scan_ch.valid = 1'b0;
        scan_ch.sense_1 = '0;
        scan_ch.sense_2 = '0;
        scan_ch.sense_3 = '0;
        scan_ch.sense_4 = '0;
        scan_ch.sense_5 = '0;
        scan_ch.sense_6 = '0;
        scan_ch.sense_7 = '0;
        scan_ch.run_enable = 1'b0;
        kp_g = KP_RESET;
        ki_g = KI_RESET;
        kd_g = KD_RESET;
        base_sp = BASE_RESET;
        on_thr = ON_THR_RESET;
        off_thr = OFF_THR_RESET;
        held_err = 0;
        line_gone = 1'b0;
        scans_sent = 0;
        beats_seen = 0;
        lost_beats = 0;
        mismatches = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
        begin
            offer_scan(DIRECTED_ROWS[i].level, DIRECTED_ROWS[i].run,
                       DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
            pause_scans(i == N_ROWS - 1);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain();
            if (ph < N_FIXED_PHASES)
                g = PHASE_GAINS[ph];
            else
            begin
                g.kp = GAIN_W'($urandom_range(255, 0));
                g.ki = GAIN_W'($urandom_range(255, 0));
                g.kd = GAIN_W'($urandom_range(255, 0));
                g.base = SPEED_W'($urandom_range(511, 0));
                g.on_thr = SENSE_W'($urandom_range(4095, 0));
                g.off_thr = SENSE_W'($urandom_range(4095, 0));
            end
            write_reg(REG_KP, g.kp);
            write_reg(REG_KI, g.ki);
            write_reg(REG_KD, g.kd);
            write_reg(REG_BASE, g.base);
            write_reg(REG_ON_THR, g.on_thr);
            write_reg(REG_OFF_THR, g.off_thr);
            cfg_we <= 1'b0;
            @(posedge clk);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                offer_scan(random_scan(), $urandom_range(3, 0) != 0, 1'b0, NO_WANT);
                pause_scans(n == ITEMS_PER_PHASE - 1);
            end
        end

        drain();
        $display("%0d scans over %0d register settings, %0d drive beats checked",
                 scans_sent, N_PHASES + 1, beats_seen);
        $display("%0d beats with line lost, %0d mismatching beats", lost_beats, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lfpd_pkg.sv
sv/lfpd_scan_if.sv
sv/lfpd_drive_if.sv
sv/lfpd_ctrl.sv
sv/lfpd_dp.sv
sv/line_follower_pd_drive.sv
sim/tb_line_follower_pd_drive.sv
